// ===== sv/rbse_pkg.sv =====
package rbse_pkg;

    // Field widths of the pixel, the symbol and the configuration registers.
    localparam int CH_W    = 8;
    localparam int PCT_W   = 7;
    localparam int DUTY_W  = 6;
    localparam int PROD_W  = CH_W + PCT_W;

    // Each pixel yields one symbol per data bit: green, red, blue, MSB first.
    localparam int BITS_PER_PIXEL = 3 * CH_W;
    localparam int CNT_W          = $clog2(BITS_PER_PIXEL);

    // Division by 100 is done as a multiply by 5243 / 2^19.
    // This is exact for every product below 43690, and the largest is 25500.
    localparam logic [PCT_W-1:0] FULL_SCALE  = 7'd100;
    localparam int               RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 13'd5243;
    localparam int               RECIP_SHIFT = 19;
    localparam int               QPROD_W     = PROD_W + RECIP_W;

    // Configuration register indexes and reset values.
    typedef enum logic [1:0] {
        REG_BRIGHTNESS = 2'd0,
        REG_ZERO_DUTY  = 2'd1,
        REG_ONE_DUTY   = 2'd2,
        REG_UNUSED     = 2'd3
    } rbse_reg_idx_t;

    localparam logic [PCT_W-1:0]  BRIGHT_RESET = 7'd100;
    localparam logic [DUTY_W-1:0] ZERO_RESET   = 6'd20;
    localparam logic [DUTY_W-1:0] ONE_RESET    = 6'd43;

    // Stage enables that the top level hands to each scaling lane.
    typedef struct packed {
        logic load_prod;
        logic load_quot;
    } rbse_lane_ctl_t;

endpackage

// ===== sv/rbse_lane.sv =====
module rbse_lane
    import rbse_pkg::*;
(
    input  logic                 aclk,
    input  rbse_lane_ctl_t       ctl,
    input  logic [CH_W-1:0]      chan,
    input  logic [PCT_W-1:0]     pct,
    output logic [CH_W-1:0]      scaled
);

    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [QPROD_W-1:0] qprod;
    logic [CH_W-1:0]    scaled_reg;
    logic [CH_W-1:0]    scaled_next;

    // First stage: channel times percent.
    assign prod_next = PROD_W'(chan) * PROD_W'(pct);

    // Second stage: divide by 100 through the reciprocal multiply.
    assign qprod       = QPROD_W'(prod_reg) * QPROD_W'(RECIP_MULT);
    assign scaled_next = qprod[RECIP_SHIFT +: CH_W];

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            prod_reg <= prod_next;
        end
        if (ctl.load_quot) begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

// ===== sv/rbse_serializer.sv =====
module rbse_serializer
    import rbse_pkg::*;
#(
    parameter int PIXELS_PER_FRAME = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CH_W-1:0]   red,
    input  logic [CH_W-1:0]   green,
    input  logic [CH_W-1:0]   blue,
    input  logic [DUTY_W-1:0] zero_duty,
    input  logic [DUTY_W-1:0] one_duty,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DUTY_W-1:0] duty,
    output logic              pixel_done,
    output logic              frame_done
);

    localparam int POS_W = (PIXELS_PER_FRAME > 1) ? $clog2(PIXELS_PER_FRAME) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PIXELS_PER_FRAME - 1);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_PIXEL - 1);

    logic [BITS_PER_PIXEL-1:0] word_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      last_pix_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          pos_next;
    logic                      out_v_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic                      plast_reg;
    logic                      flast_reg;
    logic                      emit;
    logic                      done;
    logic                      load;
    logic                      is_last_pos;

    // A symbol moves into the output register when it is empty or being taken.
    assign emit     = busy_reg && (!out_v_reg || out_ready);
    assign done     = emit && (cnt_reg == LAST_BIT);
    assign in_ready = !busy_reg || done;
    assign load     = in_valid && in_ready;

    assign is_last_pos = (pos_reg == LAST_POS);
    assign pos_next    = is_last_pos ? '0 : pos_reg + POS_W'(1);

    // Control: bit counter, busy flag, frame position and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            out_v_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                pos_reg  <= pos_next;
            end else if (done) begin
                busy_reg <= 1'b0;
            end else if (emit) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (emit) begin
                out_v_reg <= 1'b1;
            end else if (out_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Payload: merged pixel word, shifted out MSB first.
    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg     <= {green, red, blue};
            last_pix_reg <= is_last_pos;
        end else if (emit) begin
            word_reg <= {word_reg[BITS_PER_PIXEL-2:0], 1'b0};
        end
        if (emit) begin
            duty_reg  <= word_reg[BITS_PER_PIXEL-1] ? one_duty : zero_duty;
            plast_reg <= (cnt_reg == LAST_BIT);
            flast_reg <= (cnt_reg == LAST_BIT) && last_pix_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign duty       = duty_reg;
    assign pixel_done = plast_reg;
    assign frame_done = flast_reg;

endmodule

// ===== sv/rgb_led_bit_symbol_encoder.sv =====
// Converts one RGB pixel per input item into 24 LED bit symbols (green, red,
// blue, each MSB first), after scaling every channel by the brightness
// register as floor(channel * percent / 100); percent values above 100 act
// as 100. Each symbol carries zero_duty or one_duty in m_tdata, m_tlast marks
// the 24th symbol of a pixel and m_tuser marks the 24th symbol of the last
// pixel of a frame of PIXELS_PER_FRAME pixels. The output serializer sends
// one symbol per cycle while m_tready does not hold it back, and takes the
// next pixel in the cycle its last symbol leaves, so a steady input stream
// gives an unbroken symbol stream. An accepted pixel passes the product
// register, second scaling stage, serializer load and output register.
// Registers at byte addresses 0, 4, 8: brightness, zero duty, one duty.
module rgb_led_bit_symbol_encoder
    import rbse_pkg::*;
#(
    parameter int PIXELS_PER_FRAME = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Pixel input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // Symbol output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] duty, [7:6] zero
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // [0] frame_done
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [PCT_W-1:0]  bright_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [DUTY_W-1:0] zero_reg;
    logic [DUTY_W-1:0] one_reg;
    logic              wr_en;
    rbse_reg_idx_t     reg_idx;
    logic [PCT_W-1:0]  wr_pct;

    logic              p1_v_reg;
    logic              p2_v_reg;
    logic              ser_ready;
    logic              mv12;
    logic              ser_load;
    rbse_lane_ctl_t    lane_ctl;
    logic [CH_W-1:0]   red_s;
    logic [CH_W-1:0]   green_s;
    logic [CH_W-1:0]   blue_s;
    logic [DUTY_W-1:0] duty;
    logic              pixel_done;
    logic              frame_done;

    // Configuration registers; the clamped percent is kept beside the raw one.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = rbse_reg_idx_t'(paddr[3:2]);
    assign wr_pct  = pwdata[PCT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= BRIGHT_RESET;
            pct_reg    <= FULL_SCALE;
            zero_reg   <= ZERO_RESET;
            one_reg    <= ONE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BRIGHTNESS: begin
                    bright_reg <= wr_pct;
                    pct_reg    <= (wr_pct > FULL_SCALE) ? FULL_SCALE : wr_pct;
                end
                REG_ZERO_DUTY: zero_reg <= pwdata[DUTY_W-1:0];
                REG_ONE_DUTY:  one_reg  <= pwdata[DUTY_W-1:0];
                REG_UNUSED: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BRIGHTNESS: prdata = 32'(bright_reg);
            REG_ZERO_DUTY:  prdata = 32'(zero_reg);
            REG_ONE_DUTY:   prdata = 32'(one_reg);
            REG_UNUSED:     prdata = '0;
        endcase
    end

    // Two-stage scaling pipeline with per-stage valid bits.
    assign mv12     = p1_v_reg && (!p2_v_reg || ser_ready);
    assign s_tready = !p1_v_reg || !p2_v_reg || ser_ready;
    assign ser_load = p2_v_reg && ser_ready;

    assign lane_ctl.load_prod = s_tvalid && s_tready;
    assign lane_ctl.load_quot = mv12;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end else begin
            if (lane_ctl.load_prod) begin
                p1_v_reg <= 1'b1;
            end else if (mv12) begin
                p1_v_reg <= 1'b0;
            end
            if (mv12) begin
                p2_v_reg <= 1'b1;
            end else if (ser_load) begin
                p2_v_reg <= 1'b0;
            end
        end
    end

    // One scaling lane per color channel.
    rbse_lane u_lane_red (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .chan   (s_tdata[7:0]),
        .pct    (pct_reg),
        .scaled (red_s)
    );

    rbse_lane u_lane_green (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .chan   (s_tdata[15:8]),
        .pct    (pct_reg),
        .scaled (green_s)
    );

    rbse_lane u_lane_blue (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .chan   (s_tdata[23:16]),
        .pct    (pct_reg),
        .scaled (blue_s)
    );

    // Merge the lanes into one word and send it out bit by bit.
    rbse_serializer #(
        .PIXELS_PER_FRAME (PIXELS_PER_FRAME)
    ) u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (p2_v_reg),
        .in_ready   (ser_ready),
        .red        (red_s),
        .green      (green_s),
        .blue       (blue_s),
        .zero_duty  (zero_reg),
        .one_duty   (one_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .duty       (duty),
        .pixel_done (pixel_done),
        .frame_done (frame_done)
    );

    assign m_tdata = {2'b00, duty};
    assign m_tlast = pixel_done;
    assign m_tuser = frame_done;

endmodule

// ===== sv/rbse_checker.sv =====
module rbse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser
);

    // A stalled symbol holds its value and flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // The end of a frame is always the end of a pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame end without pixel end");

    // Within a pixel the symbols follow each other without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a pixel");

    // The padding bits above the duty stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:6] == 2'b00)
        else $error("nonzero padding in output item");

endmodule

bind rgb_led_bit_symbol_encoder rbse_checker u_rbse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== sim/tb_rgb_led_bit_symbol_encoder.sv =====
`timescale 1ns / 100ps

module tb_rgb_led_bit_symbol_encoder;
    import rbse_pkg::*;

    localparam int FRAME_PIXELS    = 64;
    localparam int PHASES          = 7;
    localparam int PIXELS_PER_PHASE = 60;
    localparam int STALL_LIMIT     = 1000;
    localparam int MAX_REPORTS     = 10;

    // One expected LED symbol.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              pixel_done;
        logic              frame_done;
    } led_symbol_t;

    // Predicts the symbol stream from the accepted pixels and compares it with the output.
    class pixel_symbol_model;
        logic [PCT_W-1:0]  brightness;
        logic [DUTY_W-1:0] zero_duty;
        logic [DUTY_W-1:0] one_duty;
        int unsigned       pixel_index;
        led_symbol_t       expected_symbols[$];
        int unsigned       mismatch_count;

        function new();
            brightness     = BRIGHT_RESET;
            zero_duty      = ZERO_RESET;
            one_duty       = ONE_RESET;
            pixel_index    = 0;
            mismatch_count = 0;
        endfunction

        function void write_register(rbse_reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_BRIGHTNESS: brightness = value[PCT_W-1:0];
                REG_ZERO_DUTY:  zero_duty  = value[DUTY_W-1:0];
                REG_ONE_DUTY:   one_duty   = value[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        // Brightness values above full scale act as full scale.
        function logic [CH_W-1:0] scale(logic [CH_W-1:0] level);
            int unsigned pct;
            pct = 32'((brightness > FULL_SCALE) ? FULL_SCALE : brightness);
            return CH_W'((level * pct) / FULL_SCALE);
        endfunction

        function void note_pixel(logic [23:0] data);
            logic [BITS_PER_PIXEL-1:0] word;
            logic                      last_pixel;
            led_symbol_t               sym;
            // Green, red, blue, each most significant bit first.
            word       = {scale(data[15:8]), scale(data[7:0]), scale(data[23:16])};
            last_pixel = (pixel_index == FRAME_PIXELS - 1);
            for (int k = BITS_PER_PIXEL - 1; k >= 0; k--) begin
                sym.duty       = word[k] ? one_duty : zero_duty;
                sym.pixel_done = (k == 0);
                sym.frame_done = (k == 0) && last_pixel;
                expected_symbols.push_back(sym);
            end
            pixel_index = last_pixel ? 0 : pixel_index + 1;
        endfunction

        function void flag_mismatch(string text);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s", $realtime, text);
        endfunction

        function void check_symbol(logic [7:0] data, logic last, logic frame);
            led_symbol_t want;
            if (expected_symbols.size() == 0) begin
                flag_mismatch($sformatf("unexpected symbol: data 0x%02h last %0b frame %0b",
                                        data, last, frame));
                return;
            end
            want = expected_symbols.pop_front();
            if (data !== {2'b00, want.duty})
                flag_mismatch($sformatf("duty: expected 0x%02h, got 0x%02h",
                                        {2'b00, want.duty}, data));
            if (last !== want.pixel_done)
                flag_mismatch($sformatf("pixel_done: expected %0b, got %0b",
                                        want.pixel_done, last));
            if (frame !== want.frame_done)
                flag_mismatch($sformatf("frame_done: expected %0b, got %0b",
                                        want.frame_done, frame));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] red, [15:8] green, [23:16] blue
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [5:0] duty, [7:6] zero
    logic        m_tlast;
    logic [0:0]  m_tuser;   // [0] frame_done
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pixel_symbol_model led_symbols = new();
    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    int unsigned stall_cycles;

    rgb_led_bit_symbol_encoder #(
        .PIXELS_PER_FRAME(FRAME_PIXELS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // The symbol receiver stalls at random.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Both channels are sampled at the rising edge; the watchdog counts idle cycles.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                led_symbols.note_pixel(s_tdata);
            if (m_tvalid && m_tready)
                led_symbols.check_symbol(m_tdata, m_tlast, m_tuser[0]);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("rgb_led_bit_symbol_encoder: mismatch");
                $finish;
            end
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_register(input rbse_reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        led_symbols.write_register(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Unused upper bits of each write carry random values.
    task automatic set_config(input int unsigned pct, input int unsigned zero,
                              input int unsigned one);
        write_register(REG_BRIGHTNESS, ($urandom << PCT_W) | pct);
        write_register(REG_ZERO_DUTY, ($urandom << DUTY_W) | zero);
        write_register(REG_ONE_DUTY, ($urandom << DUTY_W) | one);
    endtask

    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Holds the sender until every symbol has left, then lets the pipeline settle.
    task automatic drain_symbols();
        s_tvalid <= 1'b0;
        while (led_symbols.expected_symbols.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Channel levels lean toward the extremes now and then.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        aresetn           = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        m_tready          = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        stall_cycles      = 0;
        sender_idle_pct   = 7;
        receiver_idle_pct = 52;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int p = 0; p < PHASES; p++) begin
            // Light sender idling first, then light receiver idling, then none.
            if (p < 3) begin
                sender_idle_pct   = 7;
                receiver_idle_pct = 52;
            end else if (p < 5) begin
                sender_idle_pct   = 52;
                receiver_idle_pct = 7;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end

            case (p)
                0: begin
                    // Reset settings: channel extremes and bit patterns.
                    send_pixel(8'h00, 8'h00, 8'h00);
                    send_pixel(8'hFF, 8'hFF, 8'hFF);
                    send_pixel(8'hFF, 8'h00, 8'h00);
                    send_pixel(8'h00, 8'hFF, 8'h00);
                    send_pixel(8'h00, 8'h00, 8'hFF);
                    send_pixel(8'hAA, 8'h55, 8'hAA);
                    send_pixel(8'h55, 8'hAA, 8'h55);
                    send_pixel(8'h80, 8'h01, 8'h80);
                    send_pixel(8'h01, 8'h80, 8'h01);
                    send_pixel(8'hFE, 8'h7F, 8'h01);
                    send_pixel(8'd100, 8'd200, 8'd50);
                    send_pixel(8'd99, 8'd101, 8'd3);
                end
                // Fully dark, extreme duties.
                1: set_config(0, 0, 63);
                // Brightness register maximum acts as full scale.
                2: set_config(127, 63, 0);
                // Just above full scale, near-maximum duties, and an unknown register.
                3: begin
                    set_config(101, 62, 61);
                    write_register(REG_UNUSED, $urandom);
                end
                4: set_config(50, 20, 43);
                5: set_config(100, $urandom_range(63), $urandom_range(63));
                default: set_config($urandom_range(127), $urandom_range(63),
                                    $urandom_range(63));
            endcase

            repeat (PIXELS_PER_PHASE) send_pixel(pick_level(), pick_level(), pick_level());
            drain_symbols();
        end

        if (led_symbols.mismatch_count == 0)
            $display("rgb_led_bit_symbol_encoder: match");
        else
            $display("rgb_led_bit_symbol_encoder: mismatch");
        $finish;
    end

endmodule
